FILE: rtl/cubic_bezier_tessellator_unit_assert.svh
// Assertion macros for the cubic Bezier tessellator unit.
// Included by the RTL files that carry assertions; relies on clk and arst_n in scope.
`ifndef CUBIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cbt_pkg.sv
// Shared types and constants for the cubic Bezier tessellator unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cbt_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int SIZE_W      = 12;
	localparam int COORD_W     = 16;
	localparam int POS_W       = 18;
	localparam int T_W         = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [T_W-1:0] T_ONE = T_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_ONE,
		REG_POINT_TWO,
		REG_POINT_THREE,
		REG_POINT_FOUR,
		REG_POINT_COUNT
	} cfg_reg_t;

	localparam logic [3:0][31:0] PT_RESET = {
		32'h4000_4000, 32'h4000_0000, 32'h0000_4000, 32'h0000_0000
	};
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_POINTS);

	// Control points, entry k holds x in bits 15:0 and y in bits 31:16.
	typedef struct packed {
		logic [3:0][31:0] pt;
	} ctrl_t;

	// One run request as handed from the front to the back.
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic [IDX_W-1:0]  span;
		logic [T_W-1:0]    step_q;
		logic [IDX_W-1:0]  step_r;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/cbt_front.sv
// Front end: configuration registers, request intake and the per-run step division.
// Depends on cbt_pkg; feeds cbt_queue.
`timescale 1ns / 1ps
module cbt_front import cbt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output ctrl_t                ctrl,
	input  q_stat_t              qstat,
	output logic                 push,
	output cmd_t                 push_cmd
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_t;

	localparam int CNT_DIV_W = $clog2(T_W);

	state_t                 state_q;
	logic [3:0][31:0]       pt_q;
	logic [CNT_W-1:0]       count_q;
	logic [SIZE_W-1:0]      w_q, h_q;
	logic [IDX_W-1:0]       span_q, rem_q;
	logic [T_W-1:0]         quo_q;
	logic [CNT_DIV_W-1:0]   cnt_q;
	logic [IDX_W-1:0]       span_c;
	logic [IDX_W:0]         shifted;
	logic                   ge;
	logic                   accept;

	assign s_axis_tready = (state_q == F_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ctrl.pt       = pt_q;

	// Clamp the point count to [2, MAX_POINTS] and take one off.
	always_comb begin
		priority if (count_q < CNT_W'(2)) begin
			span_c = IDX_W'(1);
		end else if (count_q > CNT_W'(MAX_POINTS)) begin
			span_c = IDX_W'(MAX_POINTS - 1);
		end else begin
			span_c = IDX_W'(count_q - CNT_W'(1));
		end
	end

	// Restoring division of 65536 by the span, one quotient bit per cycle.
	assign shifted = {rem_q, T_ONE[cnt_q]};
	assign ge      = shifted >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q    <= PT_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POINT_ONE:   pt_q[0] <= cfg_data;
				REG_POINT_TWO:   pt_q[1] <= cfg_data;
				REG_POINT_THREE: pt_q[2] <= cfg_data;
				REG_POINT_FOUR:  pt_q[3] <= cfg_data;
				REG_POINT_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						cnt_q   <= CNT_DIV_W'(T_W - 1);
						rem_q   <= '0;
						quo_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= ge ? IDX_W'(shifted - {1'b0, span_q}) : shifted[IDX_W-1:0];
					quo_q <= {quo_q[T_W-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - CNT_DIV_W'(1);
					end
				end
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= s_axis_tdata[SIZE_W-1:0];
			h_q    <= s_axis_tdata[2*SIZE_W-1:SIZE_W];
			span_q <= span_c;
		end
	end

	assign push     = (state_q == F_PUSH) && !qstat.full;
	assign push_cmd = '{width: w_q, height: h_q, span: span_q, step_q: quo_q, step_r: rem_q};

endmodule

FILE: rtl/cbt_queue.sv
// Two-entry request queue between the front and back of the tessellator.
// Depends on cbt_pkg for the request type.
`timescale 1ns / 1ps
module cbt_queue import cbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t qstat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t                    mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]        wr_q, rd_q;
	logic [PTR_W:0]          fill_q;

	assign qstat.full  = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			fill_q <= fill_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/cbt_back.sv
// Back end: point sequencer and five-stage Bernstein evaluator whose last stage is the output register.
// Depends on cbt_pkg and the assertion macros header; pulls requests from cbt_queue.
`timescale 1ns / 1ps
`include "cubic_bezier_tessellator_unit_assert.svh"
module cbt_back import cbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	input  q_stat_t     qstat,
	input  cmd_t        head,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	localparam int A_W   = 36;
	localparam int W2_W  = 2 * T_W;
	localparam int P_W   = W2_W + 1 + A_W;
	localparam int ACC_W = 66;
	localparam int SH1   = 42;
	localparam int C_W   = ACC_W - SH1;
	localparam int S_W   = C_W + SIZE_W + 1;
	localparam int SH2   = 16;
	localparam int R_W   = S_W - SH2;
	localparam int PAD_W = 48 - IDX_W - 2 * POS_W;

	// a*pa + 3*b*pb, exact.
	function automatic logic signed [A_W-1:0] half_sum(
		input logic signed [T_W:0]     a,
		input logic signed [COORD_W-1:0] pa,
		input logic signed [T_W:0]     b,
		input logic signed [COORD_W-1:0] pb
	);
		logic signed [A_W-1:0] m0;
		logic signed [A_W-1:0] m1;
		m0 = a * pa;
		m1 = b * pb;
		return m0 + m1 + (m1 <<< 1);
	endfunction

	function automatic logic signed [POS_W-1:0] sat(input logic signed [R_W-1:0] v);
		priority if (v > R_W'(2**(POS_W-1) - 1)) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end else if (v < -R_W'(2**(POS_W-1))) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			return v[POS_W-1:0];
		end
	endfunction

	// Sequencer.
	state_t           state_q;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] idx_q, r_q, r_next;
	logic [T_W-1:0]   q_q, u_c;
	logic [IDX_W:0]   r_sum;
	logic             wrap, last_c, issue, advance, load;

	// Pipeline.
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                     last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [SIZE_W-1:0]        w_s1, w_s2, w_s3, h_s1, h_s2, h_s3;
	logic signed [A_W-1:0]    ax_s1, bx_s1, ay_s1, by_s1;
	logic [W2_W-1:0]          u2_s1, t2_s1;
	logic signed [ACC_W-1:0]  mx1_s2, mx2_s2, my1_s2, my2_s2;
	logic signed [C_W-1:0]    cx_s3, cy_s3;
	logic signed [S_W-1:0]    sx_s4, sy_s4;
	logic signed [POS_W-1:0]  px_s5, py_s5;

	logic signed [T_W:0]      t_sg, u_sg;
	logic signed [COORD_W-1:0] px [4];
	logic signed [COORD_W-1:0] py [4];
	logic signed [P_W-1:0]    pmx1, pmx2, pmy1, pmy2;
	logic signed [ACC_W-1:0]  accx, accy;
	logic signed [S_W-1:0]    rx, ry;

	assign advance = !v_s5 || m_axis_tready;
	assign issue   = advance && (state_q == S_RUN);
	assign last_c  = (idx_q == cmd_q.span);
	assign load    = !qstat.empty && ((state_q == S_IDLE) || (issue && last_c));
	assign pop     = load;

	// t advances by the quotient and remainder of 65536 / span each point.
	assign r_sum  = {1'b0, r_q} + {1'b0, cmd_q.step_r};
	assign wrap   = r_sum >= {1'b0, cmd_q.span};
	assign r_next = wrap ? IDX_W'(r_sum - {1'b0, cmd_q.span}) : r_sum[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			q_q     <= '0;
			r_q     <= '0;
		end else begin
			if (load) begin
				state_q <= S_RUN;
				idx_q   <= '0;
				q_q     <= '0;
				r_q     <= head.span >> 1;
			end else if (issue) begin
				if (last_c) begin
					state_q <= S_IDLE;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
					q_q   <= q_q + cmd_q.step_q + T_W'(wrap);
					r_q   <= r_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= head;
		end
	end

	// Stage 1: u*p0 + 3t*p1 and 3u*p2 + t*p3, plus u^2 and t^2.
	assign u_c  = T_ONE - q_q;
	assign t_sg = $signed({1'b0, q_q});
	assign u_sg = $signed({1'b0, u_c});

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			px[k] = $signed(ctrl.pt[k][COORD_W-1:0]);
			py[k] = $signed(ctrl.pt[k][2*COORD_W-1:COORD_W]);
		end
	end

	// Stage 2 products, stage 3 sum and stage 5 rounding.
	assign pmx1 = $signed({1'b0, u2_s1}) * ax_s1;
	assign pmx2 = $signed({1'b0, t2_s1}) * bx_s1;
	assign pmy1 = $signed({1'b0, u2_s1}) * ay_s1;
	assign pmy2 = $signed({1'b0, t2_s1}) * by_s1;
	assign accx = mx1_s2 + mx2_s2 + (ACC_W'(1) <<< (SH1 - 1));
	assign accy = my1_s2 + my2_s2 + (ACC_W'(1) <<< (SH1 - 1));
	assign rx   = sx_s4 + (S_W'(1) <<< (SH2 - 1));
	assign ry   = sy_s4 + (S_W'(1) <<< (SH2 - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1  <= idx_q;
			last_s1 <= last_c;
			w_s1    <= cmd_q.width;
			h_s1    <= cmd_q.height;
			ax_s1   <= half_sum(u_sg, px[0], t_sg, px[1]);
			bx_s1   <= half_sum(t_sg, px[3], u_sg, px[2]);
			ay_s1   <= half_sum(u_sg, py[0], t_sg, py[1]);
			by_s1   <= half_sum(t_sg, py[3], u_sg, py[2]);
			u2_s1   <= W2_W'(u_c) * W2_W'(u_c);
			t2_s1   <= W2_W'(q_q) * W2_W'(q_q);

			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			mx1_s2  <= pmx1[ACC_W-1:0];
			mx2_s2  <= pmx2[ACC_W-1:0];
			my1_s2  <= pmy1[ACC_W-1:0];
			my2_s2  <= pmy2[ACC_W-1:0];

			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			w_s3    <= w_s2;
			h_s3    <= h_s2;
			cx_s3   <= accx[ACC_W-1:SH1];
			cy_s3   <= accy[ACC_W-1:SH1];

			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
			sx_s4   <= cx_s3 * $signed({1'b0, w_s3});
			sy_s4   <= cy_s3 * $signed({1'b0, h_s3});

			idx_s5  <= idx_s4;
			last_s5 <= last_s4;
			px_s5   <= sat(rx[S_W-1:SH2]);
			py_s5   <= sat(ry[S_W-1:SH2]);
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tlast  = last_s5;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, py_s5, px_s5, idx_s5};

	`CBT_ASSERT_SAME(a_last_t_one, issue && last_c, q_q == T_ONE, "last point does not reach t = 1")
	`CBT_ASSERT_SAME(a_rem_below_span, state_q == S_RUN, r_q < cmd_q.span, "step remainder not below span")
	`CBT_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")

endmodule

FILE: rtl/cubic_bezier_tessellator_unit.sv
// A request word reaches the first point through the step division in the front, the queue,
// then the five evaluator stages; each request yields n points (n = clamped point count).
// Points leave at one point per cycle while the output channel accepts them. The front takes
// a new request only once the last one is divided and queued, so the serial division bounds the request rate.
// Reset: asynchronous, active low; configuration registers return to their cbt_pkg defaults, queue empties.
// Top level of the cubic Bezier tessellator; instantiates cbt_front, cbt_queue and cbt_back.
`timescale 1ns / 1ps
module cubic_bezier_tessellator_unit import cbt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request channel.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // canvas_width [11:0], canvas_height [23:12]
	// Point channel.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [47:0]          m_axis_tdata,   // point_index [5:0], pos_x [23:6], pos_y [41:24]
	output logic                 m_axis_tlast,   // last_point
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// The register file always takes a write word at once. Writes to an index beyond
	// the point count register are dropped.
	ctrl_t   ctrl;
	q_stat_t qstat;
	cmd_t    push_cmd, head;
	logic    push, pop;

	assign cfg_ready = 1'b1;

	// The front takes one request word, clamps the point count and works out the
	// per-point step of t (quotient and remainder of 65536 over the span) bit by bit.
	cbt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ctrl          (ctrl),
		.qstat         (qstat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// The queue lets the front prepare the next run while the back still emits points.
	cbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// The back steps t exactly, evaluates the Bernstein sum, scales by the canvas size,
	// rounds and saturates. The whole evaluator stalls while the output word waits.
	cbt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.qstat         (qstat),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
